FILE: src/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes and control types of the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    FUNC_STEP   = 2'd0,
    FUNC_SCHED  = 2'd1,
    FUNC_DUP    = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Word index of the queue_limit register (paddr bit 2)
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  // Datapath operation for the current cycle
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_STEP   = 2'd1,
    OP_DROP   = 2'd2,
    OP_INSERT = 2'd3
  } dp_op_t;

  // Controller to datapath command
  typedef struct packed {
    dp_op_t op;
    logic   use_latched;  // take task and due time from the held copy
    logic   latch;        // capture task and due time from the input beat
    logic   report;       // load the result register
  } stq_cmd_t;

endpackage

FILE: src/sorted_timer_event_queue.sv
// Results: step, duplicate schedule and remove load the result at the accepting edge;
//   schedule with replace runs a drop pass, then an insert pass that loads the result.
// Throughput: one beat per cycle while the result channel is not stalled; schedule with
//   replace holds off the input for its insert pass, as each pass uses the single cell row.
// Reset: clears the entry count and result valid, sets queue_limit to the
//   built depth; cell contents are left as they are.
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Due-time-ordered queue of (task id, due time) entries with schedule,
// duplicate schedule, remove and step operations.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int TIME_BITS    = 32,
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [TASK_ID_BITS-1:0] in_task_id,
  input  logic [TIME_BITS-1:0]    in_due_time,
  input  logic [TIME_BITS-1:0]    in_now,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic                    out_fired,
  output logic [TASK_ID_BITS-1:0] out_fired_task,
  output logic [CNT_W-1:0]        out_entry_count,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import stq_pkg::*;

  logic [CNT_W-1:0] queue_limit_r, queue_limit_nxt;
  logic             cfg_wr;
  stq_cmd_t         cmd;

  // Configuration: one register, queue_limit, at word 0. Writes to other
  // words are dropped; reads of them return zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign queue_limit_nxt = (cfg_wr && paddr[2] == REG_QUEUE_LIMIT)
                           ? pwdata[CNT_W-1:0] : queue_limit_r;

  assign prdata = (paddr[2] == REG_QUEUE_LIMIT) ? 32'(queue_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= CNT_W'(QUEUE_DEPTH);
    end else begin
      queue_limit_r <= queue_limit_nxt;
    end
  end

  // Controller: decode the operation, sequence the drop and insert passes
  // and hold off the input while a result beat cannot be replaced or an insert pass is pending.
  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: the cell row, entry count and result register.
  stq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS),
    .TIME_BITS    (TIME_BITS),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .queue_limit     (queue_limit_r),
    .in_task_id      (in_task_id),
    .in_due_time     (in_due_time),
    .in_now          (in_now),
    .out_status      (out_status),
    .out_fired       (out_fired),
    .out_fired_task  (out_fired_task),
    .out_entry_count (out_entry_count)
  );

endmodule

FILE: src/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// Controller: accepts input beats, sequences drop and insert passes, owns
// the result valid flag.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output stq_pkg::stq_cmd_t cmd
);
  import stq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_INSERT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  func_t  func;

  assign slot_free = !out_valid_r || !out_stall;
  assign func      = func_t'(in_func);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    cmd.op          = OP_NONE;
    cmd.use_latched = 1'b0;
    cmd.latch       = 1'b0;
    cmd.report      = 1'b0;
    in_stall        = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !slot_free;
        if (in_valid && slot_free) begin
          unique case (func)
            FUNC_STEP: begin
              cmd.op     = OP_STEP;
              cmd.report = 1'b1;
            end
            FUNC_SCHED: begin
              cmd.op    = OP_DROP;
              cmd.latch = 1'b1;
              state_nxt = S_INSERT;
            end
            FUNC_DUP: begin
              cmd.op     = OP_INSERT;
              cmd.report = 1'b1;
            end
            FUNC_REMOVE: begin
              cmd.op     = OP_DROP;
              cmd.report = 1'b1;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_INSERT: begin
        cmd.op          = OP_INSERT;
        cmd.use_latched = 1'b1;
        cmd.report      = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.report ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/stq_datapath.sv
// ----------------------------------------------------------------------------
// stq_datapath
// Row of compare-and-shift cells holding the queue, entry count and the
// result register.
// ----------------------------------------------------------------------------
module stq_datapath #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int TIME_BITS    = 32,
  parameter int CNT_W        = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stq_pkg::stq_cmd_t       cmd,
  input  logic [CNT_W-1:0]        queue_limit,
  input  logic [TASK_ID_BITS-1:0] in_task_id,
  input  logic [TIME_BITS-1:0]    in_due_time,
  input  logic [TIME_BITS-1:0]    in_now,
  output logic [1:0]              out_status,
  output logic                    out_fired,
  output logic [TASK_ID_BITS-1:0] out_fired_task,
  output logic [CNT_W-1:0]        out_entry_count
);
  import stq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [QUEUE_DEPTH-1:0] LOW_BIT = QUEUE_DEPTH'(1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  logic [TASK_ID_BITS-1:0] slot_task_r [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]    slot_time_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [TASK_ID_BITS-1:0] task_r;
  logic [TIME_BITS-1:0]    due_r;

  logic [TASK_ID_BITS-1:0] cur_task;
  logic [TIME_BITS-1:0]    cur_due;
  logic [QUEUE_DEPTH-1:0]  in_use, match, hi_match, shift_dn, stop, at_or_past, past_prev;
  logic                    found, full, fire;
  logic [CNT_W-1:0]        eff_limit;
  logic [IDX_W-1:0]        top_idx;
  status_t                 status;

  // Neighbor values seen by each cell
  logic [TASK_ID_BITS-1:0] above_task [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] below_task [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]    above_time [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]    below_time [QUEUE_DEPTH];

  function automatic logic time_after(input logic [TIME_BITS-1:0] a,
                                      input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  assign cur_task  = cmd.use_latched ? task_r : in_task_id;
  assign cur_due   = cmd.use_latched ? due_r  : in_due_time;
  assign eff_limit = (queue_limit > DEPTH_CNT) ? DEPTH_CNT : queue_limit;
  assign full      = count_r >= eff_limit;
  assign top_idx   = IDX_W'(count_r - CNT_W'(1));

  // Per-cell compares
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      in_use[i] = CNT_W'(i) < count_r;
      match[i]  = in_use[i] && (slot_task_r[i] == cur_task);
      stop[i]   = !in_use[i] || !time_after(slot_time_r[i], cur_due);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      // highest matching cell: the one that fires soonest
      hi_match[i]   = match[i] && ((match >> i) == LOW_BIT);
      shift_dn[i]   = |(hi_match << (QUEUE_DEPTH - 1 - i));
      at_or_past[i] = |(stop << (QUEUE_DEPTH - 1 - i));
    end
    past_prev = at_or_past << 1;
  end

  assign found = |match;
  assign fire  = (count_r != '0) && !time_after(slot_time_r[top_idx], in_now);

  // The top cell sees itself above, the bottom cell itself below
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
      above_task[k] = slot_task_r[k+1];
      above_time[k] = slot_time_r[k+1];
    end
    above_task[QUEUE_DEPTH-1] = slot_task_r[QUEUE_DEPTH-1];
    above_time[QUEUE_DEPTH-1] = slot_time_r[QUEUE_DEPTH-1];
    below_task[0] = slot_task_r[0];
    below_time[0] = slot_time_r[0];
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      below_task[k] = slot_task_r[k-1];
      below_time[k] = slot_time_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      if (cmd.op == OP_DROP && found && shift_dn[k]) begin
        slot_task_r[k] <= above_task[k];
        slot_time_r[k] <= above_time[k];
      end else if (cmd.op == OP_INSERT && !full) begin
        if (past_prev[k]) begin
          slot_task_r[k] <= below_task[k];
          slot_time_r[k] <= below_time[k];
        end else if (stop[k]) begin
          slot_task_r[k] <= cur_task;
          slot_time_r[k] <= cur_due;
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    unique case (cmd.op)
      OP_STEP: begin
        if (fire) count_nxt = count_r - CNT_W'(1);
      end
      OP_DROP: begin
        if (found) count_nxt = count_r - CNT_W'(1);
        else       status    = ST_NOT_FOUND;
      end
      OP_INSERT: begin
        if (!full) count_nxt = count_r + CNT_W'(1);
        else       status    = ST_FULL;
      end
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      task_r <= in_task_id;
      due_r  <= in_due_time;
    end
    if (cmd.report) begin
      out_status      <= status;
      out_fired       <= (cmd.op == OP_STEP) && fire;
      out_fired_task  <= ((cmd.op == OP_STEP) && fire) ? slot_task_r[top_idx] : '0;
      out_entry_count <= count_nxt;
    end
  end

endmodule

FILE: src/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the sorted timer event queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8,
  parameter int CNT_W        = 5
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_func,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              out_status,
  input logic                    out_fired,
  input logic [TASK_ID_BITS-1:0] out_fired_task,
  input logic [CNT_W-1:0]        out_entry_count
);
  import stq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_fired)
      && $stable(out_fired_task) && $stable(out_entry_count))
    else $error("stalled result beat changed");

  // every single-pass operation reports in the next cycle
  a_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func != FUNC_SCHED |=> out_valid)
    else $error("result missing after single-pass operation");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_status == ST_OK)
    else $error("fired beat with error status");

  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_task == '0)
    else $error("task id shown without a fire");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

endmodule

bind sorted_timer_event_queue stq_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .TASK_ID_BITS (TASK_ID_BITS),
  .CNT_W        (CNT_W)
) u_stq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_fired       (out_fired),
  .out_fired_task  (out_fired_task),
  .out_entry_count (out_entry_count)
);

FILE: bench/sorted_timer_event_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_test
// Self-checking bench for the sorted timer event queue: a directed table
// of corner beats, then random schedule/remove/step traffic over several
// queue limits. Result beats are checked against an in-bench predictor or
// a typed row's expectation, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_test;
  import stq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;    // replace runs a second, insert pass; leave margin
  localparam int LONG_HOLD     = 200;  // receiver back-off that fills the block
  localparam int NUM_PHASES    = 5;

  // One result beat as the block reports it
  typedef struct {
    status_t    status;
    logic       fired;
    logic [7:0] fired_task;
    logic [4:0] count;
  } outcome_t;

  // One row of the directed table: either a limit write or an input beat
  typedef struct {
    bit          is_cfg;
    logic [4:0]  limit_val;
    func_t       func;
    logic [7:0]  task_id;
    logic [31:0] due;
    logic [31:0] now;
    bit          typed;
    outcome_t    exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = 2'd0;
  logic [7:0]  in_task_id = 8'd0;
  logic [31:0] in_due_time = 32'd0;
  logic [31:0] in_now = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_fired;
  logic [7:0]  out_fired_task;
  logic [4:0]  out_entry_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the queue: index count-1 is the entry that fires next
  logic [7:0]  sq_task [DEPTH];
  logic [31:0] sq_time [DEPTH];
  int          sq_count = 0;
  logic [4:0]  sq_limit = 5'd16;

  outcome_t    outcome_q [$];   // expected result beats, oldest first
  outcome_t    want;
  int          err_count = 0;
  int          cycle_count = 0;
  bit          long_hold_req = 1'b0;

  sorted_timer_event_queue uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_task_id      (in_task_id),
    .in_due_time     (in_due_time),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_fired       (out_fired),
    .out_fired_task  (out_fired_task),
    .out_entry_count (out_entry_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Queue predictor
  // ---------------------------------------------------------------------------

  // Wrap-aware: a is after b when the modular distance is nonzero and below half range
  function automatic bit is_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  // Drop the soonest-firing entry of a task; scan from the top down
  function automatic bit drop_soonest(logic [7:0] id);
    for (int i = sq_count - 1; i >= 0; i--) begin
      if (sq_task[i] == id) begin
        for (int k = i; k + 1 < sq_count; k++) begin
          sq_task[k] = sq_task[k + 1];
          sq_time[k] = sq_time[k + 1];
        end
        sq_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Insert below every entry that is not later, so equal times fire oldest first
  function automatic status_t add_entry(logic [7:0] id, logic [31:0] t);
    int pos;
    int cap;
    cap = (sq_limit > DEPTH) ? DEPTH : sq_limit;
    if (sq_count >= cap) return ST_FULL;
    pos = 0;
    while (pos < sq_count && is_later(sq_time[pos], t)) pos++;
    for (int k = sq_count; k > pos; k--) begin
      sq_task[k] = sq_task[k - 1];
      sq_time[k] = sq_time[k - 1];
    end
    sq_task[pos] = id;
    sq_time[pos] = t;
    sq_count++;
    return ST_OK;
  endfunction

  function automatic outcome_t predict_beat(func_t f, logic [7:0] id, logic [31:0] due,
                                            logic [31:0] now);
    outcome_t r;
    r.status     = ST_OK;
    r.fired      = 1'b0;
    r.fired_task = 8'd0;
    case (f)
      FUNC_STEP: begin
        if (sq_count > 0 && !is_later(sq_time[sq_count - 1], now)) begin
          sq_count--;
          r.fired      = 1'b1;
          r.fired_task = sq_task[sq_count];
        end
      end
      FUNC_SCHED: begin
        // a missing old entry is fine; the limit is checked after the drop
        void'(drop_soonest(id));
        r.status = add_entry(id, due);
      end
      FUNC_DUP: begin
        r.status = add_entry(id, due);
      end
      default: begin
        if (!drop_soonest(id)) r.status = ST_NOT_FOUND;
      end
    endcase
    r.count = sq_count[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic row_t op_row(func_t f, logic [7:0] id, logic [31:0] due,
                                  logic [31:0] now);
    row_t rw;
    rw.is_cfg    = 1'b0;
    rw.limit_val = 5'd0;
    rw.func      = f;
    rw.task_id   = id;
    rw.due       = due;
    rw.now       = now;
    rw.typed     = 1'b0;
    rw.exp.status     = ST_OK;
    rw.exp.fired      = 1'b0;
    rw.exp.fired_task = 8'd0;
    rw.exp.count      = 5'd0;
    return rw;
  endfunction

  function automatic row_t typed_row(func_t f, logic [7:0] id, logic [31:0] due,
                                     logic [31:0] now, status_t st, logic fired,
                                     logic [7:0] ftask, logic [4:0] cnt);
    row_t rw;
    rw = op_row(f, id, due, now);
    rw.typed          = 1'b1;
    rw.exp.status     = st;
    rw.exp.fired      = fired;
    rw.exp.fired_task = ftask;
    rw.exp.count      = cnt;
    return rw;
  endfunction

  function automatic row_t cfg_row(logic [4:0] v);
    row_t rw;
    rw = op_row(FUNC_STEP, 8'd0, 32'd0, 32'd0);
    rw.is_cfg    = 1'b1;
    rw.limit_val = v;
    return rw;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one input beat after a random gap; predict once the block takes it.
  // Valid stays high across back-to-back beats and drops only for a real gap.
  task automatic send_beat(func_t f, logic [7:0] id, logic [31:0] due, logic [31:0] now,
                           bit calm, bit typed, outcome_t typed_exp);
    int gap;
    outcome_t r;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_task_id  <= id;
    in_due_time <= due;
    in_now      <= now;
    do @(posedge clk); while (in_stall);
    r = predict_beat(f, id, due, now);
    if (typed) begin
      outcome_q.push_back(typed_exp);
    end else begin
      outcome_q.push_back(r);
    end
  endtask

  // Hold the input idle until every expected beat is back, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write queue_limit through the APB port: setup cycle, then access cycle
  task automatic write_limit(logic [4:0] v);
    logic [31:0] w;
    wait_idle();
    w       = $urandom;
    w[4:0]  = v;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_QUEUE_LIMIT, 2'b00};
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sq_limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long back-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    int beats;
    bit recv_calm;
    beats     = 0;
    recv_calm = 1'b0;
    forever begin
      if (beats % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (long_hold_req) begin
        // stall for a long stretch so the block backs up and stalls its input
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        hold = recv_calm ? 0 : $urandom_range(0, 14);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("fired", want.fired, out_fired);
        check_field("fired_task", want.fired_task, out_fired_task);
        check_field("entry_count", want.count, out_entry_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t        rows [$];
    outcome_t    no_exp;
    logic [4:0]  phase_limit [NUM_PHASES];
    int          phase_items [NUM_PHASES];
    int          step_pct;
    int          r;
    bit          calm;
    func_t       f;
    logic [7:0]  id;
    logic [31:0] due;
    logic [31:0] now;
    logic [31:0] now_ticks;

    no_exp = '{ST_OK, 1'b0, 8'd0, 5'd0};

    // Reset state: empty queue, then extremes of id and time
    rows.push_back(typed_row(FUNC_STEP, 8'h00, 32'h0, 32'h0, ST_OK, 1'b0, 8'h00, 5'd0));
    rows.push_back(typed_row(FUNC_REMOVE, 8'hFF, 32'h0, 32'h0, ST_NOT_FOUND, 1'b0, 8'h00,
                             5'd0));
    rows.push_back(typed_row(FUNC_DUP, 8'h00, 32'h0, 32'h0, ST_OK, 1'b0, 8'h00, 5'd1));
    rows.push_back(op_row(FUNC_SCHED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // equal time duplicate of the same task, then replace drops the soonest one
    rows.push_back(op_row(FUNC_DUP, 8'hFF, 32'hFFFF_FFFF, 32'h0));
    rows.push_back(op_row(FUNC_SCHED, 8'hFF, 32'h5, 32'h0));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'h7FFF_FFFE));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'h0));
    // nothing due yet
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'h4));
    rows.push_back(op_row(FUNC_REMOVE, 8'hFF, 32'h0, 32'h0));
    // equal times fire in insertion order
    rows.push_back(op_row(FUNC_DUP, 8'h01, 32'd100, 32'h0));
    rows.push_back(op_row(FUNC_DUP, 8'h02, 32'd100, 32'h0));
    rows.push_back(op_row(FUNC_DUP, 8'h03, 32'd100, 32'h0));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'd100));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'd100));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'd100));
    // wrap compare: one tick early, then exactly half the range away
    rows.push_back(op_row(FUNC_DUP, 8'hA5, 32'h10, 32'h0));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'h0F));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'h8000_0010));
    // lower the limit below the held count: inserts refused, replace still drops
    rows.push_back(op_row(FUNC_DUP, 8'h33, 32'd1000, 32'h0));
    rows.push_back(op_row(FUNC_DUP, 8'hCC, 32'd2000, 32'h0));
    rows.push_back(cfg_row(5'd1));
    rows.push_back(op_row(FUNC_DUP, 8'h11, 32'h0, 32'h0));
    rows.push_back(op_row(FUNC_SCHED, 8'h33, 32'd500, 32'h0));
    rows.push_back(cfg_row(5'd0));
    rows.push_back(op_row(FUNC_REMOVE, 8'h33, 32'h0, 32'h0));
    rows.push_back(op_row(FUNC_REMOVE, 8'hCC, 32'h0, 32'h0));
    rows.push_back(op_row(FUNC_STEP, 8'h00, 32'h0, 32'h0));

    // Random phases: limit above depth, small, zero, reset value, then a random one
    phase_limit = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd0};
    phase_limit[NUM_PHASES - 1] = 5'($urandom_range(1, 15));
    phase_items = '{300, 200, 60, 240, 200};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_limit(rows[i].limit_val);
      end else begin
        send_beat(rows[i].func, rows[i].task_id, rows[i].due, rows[i].now, 1'b0,
                  rows[i].typed, rows[i].exp);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      // start one phase just below the wrap point of the time counter
      now_ticks = (p == 1) ? 32'hFFFF_FF00 : $urandom;
      // fewer steps in the first phase so the queue fills to its depth
      step_pct  = (p == 0) ? 15 : 30;
      if (p == 3) long_hold_req = 1'b1;
      calm = 1'b0;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // keep offering back to back while the receiver backs off
        if (p == 3 && n < 60) calm = 1'b1;

        r = $urandom_range(0, 99);
        if (r < step_pct) f = FUNC_STEP;
        else if (r < step_pct + 35) f = FUNC_SCHED;
        else if (r < step_pct + 55) f = FUNC_DUP;
        else f = FUNC_REMOVE;

        // mostly a small pool of ids so replace and remove find matches
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));

        case ($urandom_range(0, 19))
          0:       due = $urandom;
          1:       due = now_ticks - $urandom_range(0, 100);
          2:       due = now_ticks + 32'd50;
          default: due = now_ticks + $urandom_range(0, 300);
        endcase

        if (f == FUNC_STEP) begin
          now_ticks = now_ticks + $urandom_range(0, 60);
          now = now_ticks;
        end else begin
          now = $urandom;
        end

        send_beat(f, id, due, now, calm, 1'b0, no_exp);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
